/* hw/rtl/midpoint_line_rasterizer_macros.svh */
// Assertion macros used by the rasterizer top level.
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MLR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MLR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mlr_pkg.sv */
// Shared types and constants of the midpoint line rasterizer.
`default_nettype none
package mlr_pkg;

	localparam int COORD_BITS_DEF = 12;
	// headroom of the doubled line function over the coordinate width
	localparam int DEC_EXTRA = 6;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// octant class: steep = y is the major axis, neg = negative or zero slope
	typedef struct packed {
		logic steep;
		logic neg;
	} line_case_t;

endpackage
`default_nettype wire

/* hw/rtl/mlr_load.sv */
// Endpoint ordering, classification and line coefficients for a load word.
`default_nettype none
module mlr_load
	import mlr_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF
) (
	input  wire logic signed [CB-1:0] sx,
	input  wire logic signed [CB-1:0] sy,
	input  wire logic signed [CB-1:0] ex,
	input  wire logic signed [CB-1:0] ey,
	output logic signed [CB-1:0]      x0,
	output logic signed [CB-1:0]      y0,
	output logic signed [CB-1:0]      stop,
	output logic signed [CB:0]        coef_a,
	output logic signed [CB:0]        coef_b,
	output line_case_t                lcase
);

	logic signed [CB:0] dx, dy;
	logic        [CB:0] mag_dx, mag_dy;
	logic               steep, pos, start_first;
	logic signed [CB-1:0] x1, y1;

	always_comb begin
		dx = {sx[CB-1], sx} - {ex[CB-1], ex};
		dy = {sy[CB-1], sy} - {ey[CB-1], ey};
		mag_dx = dx[CB] ? -dx : dx;
		mag_dy = dy[CB] ? -dy : dy;
		steep = !(mag_dy < mag_dx);
		pos = (dx != '0) && (dy != '0) && (dx[CB] == dy[CB]);
		start_first = steep ? (sy < ey) : (sx < ex);
		if (start_first) begin
			x0 = sx; y0 = sy; x1 = ex; y1 = ey;
		end else begin
			x0 = ex; y0 = ey; x1 = sx; y1 = sy;
		end
		coef_a = {y0[CB-1], y0} - {y1[CB-1], y1};
		coef_b = {x1[CB-1], x1} - {x0[CB-1], x0};
		stop = steep ? y1 : x1;
		lcase.steep = steep;
		lcase.neg = !pos;
	end

endmodule
`default_nettype wire

/* hw/rtl/mlr_step.sv */
// Midpoint decision and next-pixel update for one step word.
`default_nettype none
module mlr_step
	import mlr_pkg::*;
#(
	parameter int CB = COORD_BITS_DEF,
	parameter int DW = COORD_BITS_DEF + DEC_EXTRA
) (
	input  wire logic signed [CB-1:0] cur_x,
	input  wire logic signed [CB-1:0] cur_y,
	input  wire logic signed [CB-1:0] stop,
	input  wire logic signed [CB:0]   coef_a,
	input  wire logic signed [CB:0]   coef_b,
	input  wire logic signed [DW-1:0] fval,
	input  wire line_case_t           lcase,
	output logic signed [CB-1:0]      nxt_x,
	output logic signed [CB-1:0]      nxt_y,
	output logic signed [DW-1:0]      nxt_f,
	output logic                      is_last
);

	logic signed [DW-1:0] a_ext, b_ext, maj, mnr, mnr_sgn, dec;
	logic signed [CB-1:0] major, minor_step;
	logic                 take;

	always_comb begin
		// fval holds twice the line function at the current pixel
		a_ext = {{(DW-CB-1){coef_a[CB]}}, coef_a};
		b_ext = {{(DW-CB-1){coef_b[CB]}}, coef_b};
		maj = lcase.steep ? b_ext : a_ext;
		mnr = lcase.steep ? a_ext : b_ext;
		mnr_sgn = lcase.neg ? -mnr : mnr;
		dec = fval + (maj <<< 1) + mnr_sgn;
		take = dec[DW-1] ^ lcase.steep ^ lcase.neg;
		nxt_f = fval + (maj <<< 1) + (take ? (mnr_sgn <<< 1) : '0);

		major = lcase.steep ? cur_y : cur_x;
		is_last = (major >= stop);

		minor_step = lcase.neg ? -CB'(1) : CB'(1);
		if (lcase.steep) begin
			nxt_y = cur_y + CB'(1);
			nxt_x = take ? cur_x + minor_step : cur_x;
		end else begin
			nxt_x = cur_x + CB'(1);
			nxt_y = take ? cur_y + minor_step : cur_y;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/midpoint_line_rasterizer.sv */
// Top level of the midpoint line rasterizer.
`default_nettype none
`include "midpoint_line_rasterizer_macros.svh"
// A load word (command 0) takes two signed endpoints, orders them along the
// major axis and classifies the line as shallow or steep and as positive or
// negative/zero slope; it gives no pixel and replaces any line in progress.
// Each step word (command 1) while a line is active gives one pixel, the first
// being the ordered first endpoint; the final endpoint comes with last set,
// after which steps give nothing until the next load. Rate: one word per
// cycle, load or step, while the sink does not stall; a word is held in the
// input register and its pixel is then registered in the result register.
// The per-step cost is a single add-and-sign test on the doubled line function,
// kept incrementally (it is zero at the first endpoint, which lies on the
// line), so no multiplier sits in the step path. Input stall rises only when
// the result register holds a pixel the sink is stalling.
module midpoint_line_rasterizer
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          command,
	input  wire logic signed [COORD_BITS-1:0]  start_x,
	input  wire logic signed [COORD_BITS-1:0]  start_y,
	input  wire logic signed [COORD_BITS-1:0]  end_x,
	input  wire logic signed [COORD_BITS-1:0]  end_y,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_BITS-1:0]       pixel_x,
	output logic signed [COORD_BITS-1:0]       pixel_y,
	output logic                               last
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + DEC_EXTRA;

	// input register
	logic                 valid_s1;
	logic                 cmd_s1;
	logic signed [CB-1:0] sx_s1, sy_s1, ex_s1, ey_s1;

	// line state
	logic signed [CB-1:0] cur_x_q, cur_y_q, stop_q;
	logic signed [CB:0]   coef_a_q, coef_b_q;
	logic signed [DW-1:0] f_q;
	line_case_t           lcase_q;
	logic                 active_q;

	// result register
	logic                 out_valid_q;
	logic signed [CB-1:0] pix_x_q, pix_y_q;
	logic                 last_q;

	// load path
	logic signed [CB-1:0] ld_x0, ld_y0, ld_stop;
	logic signed [CB:0]   ld_a, ld_b;
	line_case_t           ld_case;

	// step path
	logic signed [CB-1:0] st_x, st_y;
	logic signed [DW-1:0] st_f;
	logic                 st_last;

	logic out_free, fire, in_take, do_load, do_step;

	mlr_load #(.CB(CB)) u_load (
		.sx(sx_s1), .sy(sy_s1), .ex(ex_s1), .ey(ey_s1),
		.x0(ld_x0), .y0(ld_y0), .stop(ld_stop),
		.coef_a(ld_a), .coef_b(ld_b), .lcase(ld_case)
	);

	mlr_step #(.CB(CB), .DW(DW)) u_step (
		.cur_x(cur_x_q), .cur_y(cur_y_q), .stop(stop_q),
		.coef_a(coef_a_q), .coef_b(coef_b_q), .fval(f_q), .lcase(lcase_q),
		.nxt_x(st_x), .nxt_y(st_y), .nxt_f(st_f), .is_last(st_last)
	);

	// word in s1 moves on whenever the result register can take a pixel
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;
	assign do_load  = fire && (cmd_s1 == CMD_LOAD);
	assign do_step  = fire && (cmd_s1 == CMD_STEP) && active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1 <= command;
			sx_s1  <= start_x;
			sy_s1  <= start_y;
			ex_s1  <= end_x;
			ey_s1  <= end_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (do_load) begin
			active_q <= 1'b1;
		end else if (do_step && st_last) begin
			active_q <= 1'b0;
		end
	end

	// endpoint lies on the line, so the doubled line function starts at zero
	always_ff @(posedge clk) begin
		if (do_load) begin
			cur_x_q  <= ld_x0;
			cur_y_q  <= ld_y0;
			stop_q   <= ld_stop;
			coef_a_q <= ld_a;
			coef_b_q <= ld_b;
			lcase_q  <= ld_case;
			f_q      <= '0;
		end else if (do_step && !st_last) begin
			cur_x_q <= st_x;
			cur_y_q <= st_y;
			f_q     <= st_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			pix_x_q <= cur_x_q;
			pix_y_q <= cur_y_q;
			last_q  <= st_last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pix_x_q;
	assign pixel_y   = pix_y_q;
	assign last      = last_q;

	`MLR_ASSERT_NOW(a_stall_needs_word, in_stall, valid_s1 && out_valid_q, "input stalled with no blocking pixel")
	`MLR_ASSERT_NEXT(a_load_arms, do_load, active_q && !out_valid_q || active_q && out_valid_q, "load did not arm the line")
	`MLR_ASSERT_NEXT(a_last_ends_line, do_step && st_last, !active_q && out_valid_q && last_q, "final pixel did not end the line")
	`MLR_ASSERT_NEXT(a_step_idle_no_pixel, fire && !do_load && !active_q && !out_valid_q, !out_valid_q, "pixel emitted while idle")

endmodule
`default_nettype wire
